>>> hdl/itsp_pkg.sv
package itsp_pkg;

  typedef logic signed [31:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  localparam logic [60:0]        LOG2E_Q60 = 61'h1715_4765_2B82_FE17;
  localparam logic [63:0]        LN2_Q64   = 64'hB172_17F7_D1CF_79AC;
  localparam logic [60:0]        ONE_Q60   = 61'h1000_0000_0000_0000;
  localparam logic signed [63:0] SUM_INIT  = 64'sh1000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_HALF_STEP,
    REG_CONTACT_GAIN,
    REG_BMF_GAIN,
    REG_DIPOLE_GAIN
  } reg_idx_e;

  typedef struct packed {
    word_t psi_re;
    word_t psi_im;
    word_t ext_potential;
    word_t dipolar_field;
    logic  interior;
  } itsp_in_t;

  typedef struct packed {
    word_t new_re;
    word_t new_im;
  } itsp_out_t;

  typedef struct packed {
    word_t             re;
    word_t             im;
    logic              interior;
    logic signed [9:0] m;
  } side_t;

  typedef struct packed {
    logic [60:0]        term;
    logic signed [63:0] sum;
    logic [59:0]        r;
    side_t              side;
  } tay_t;

  function automatic word_t sat_mag(input logic neg, input logic [63:0] m);
    word_t r;
    if (neg) begin
      if (m > 64'h8000_0000) r = WORD_MIN;
      else r = word_t'(32'd0 - m[31:0]);
    end else begin
      if (m > 64'h7FFF_FFFF) r = WORD_MAX;
      else r = word_t'(m[31:0]);
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [32:0] s;
    word_t              r;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) r = WORD_MAX;
    else if (s < -33'sd2147483648) r = WORD_MIN;
    else r = word_t'(s[31:0]);
    return r;
  endfunction

  function automatic word_t mulq(input word_t a, input word_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] pr;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    p  = 64'(ma) * 64'(mb);
    pr = (p >> 24) + 64'(p[23]);
    return sat_mag(a[31] ^ b[31], pr);
  endfunction

endpackage

>>> hdl/imag_time_potential_half_step_core.sv
// Throughput: one cell per cycle while the skid register is empty (in_stall_o low);
// the front, square root, exponent series and scale stages are all fully pipelined,
// with a skid register at the output.
// Reset: asynchronous, active low; clears all valid bits, the half-step register and the three gain registers to 0.
module imag_time_potential_half_step_core import itsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  itsp_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output itsp_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  typedef struct packed {
    logic [31:0] rem;
    logic [27:0] root;
    logic [55:0] rad;
    word_t       d;
    word_t       v;
    side_t       side;
  } sq_t;

  typedef enum logic [1:0] {SCL_SHIFT, SCL_ZERO, SCL_SAT} scl_e;

  logic [30:0] half_step_q;
  word_t       contact_q, bmf_q, dipole_q;

  logic en;
  logic [4:0] vf_q;
  logic [6:0] sq_vld_q;
  logic [8:0] vg_q;
  logic [3:0] vp_q;
  logic [24:0] tay_vld;
  tay_t        tay_data [25];

  itsp_in_t in0_q;
  side_t    side1_q, side2_q, side3_q, side4_q;
  word_t    sqre1_q, sqim1_q, dip1_q, ext1_q;
  word_t    d2_q, v2_q, d3_q, v3_q, cd3_q, d4_q, v4_q;

  sq_t sq_q  [7];
  sq_t sq_in [7];
  sq_t sq_nx [7];

  side_t       side_a_q, side_b_q, side_c_q, side_d_q, side_e_q, side_f_q, side_g_q, side_h_q;
  word_t       v_a_q, p_a_q, v_b_q, b_b_q, v_c_q, x_d_q;
  logic        xneg_e_q, xneg_f_q;
  logic [60:0] yh_e_q;
  logic [63:0] yl_e_q;
  logic [92:0] y_f_q;
  logic [59:0] u_g_q;
  logic [61:0] hh_q, hl_q, lh_q, ll_q;
  tay_t        tay0_q;

  logic [31:0]       ax;
  logic [8:0]        ny;
  logic [83:0]       frac;
  logic [84:0]       nfrac;
  logic signed [9:0] nys;
  logic [59:0]       u_d;
  logic signed [9:0] m_d;
  logic [123:0]      rfull;
  tay_t              tay0_d;

  side_t             side_p1_q, side_p2_q, side_p3_q;
  logic [60:0]       prh_re_q, prh_im_q;
  logic [63:0]       prl_re_q, prl_im_q;
  logic [92:0]       prod_re_q, prod_im_q;
  logic signed [10:0] s_p2_q;
  logic [92:0]       qs_re_q, qs_im_q;
  scl_e              kind_re_q, kind_im_q;
  itsp_out_t         res_q;

  logic [60:0]  e_val;
  logic [31:0]  mre, mim;
  logic [6:0]   sh;
  itsp_out_t    res_d;

  logic      out_vld_q, skid_vld_q;
  itsp_out_t out_q, skid_q;

  function automatic scl_e scl_kind(input logic [92:0] prod, input logic signed [10:0] s);
    scl_e k;
    if (s > 11'sd126) k = SCL_ZERO;
    else if (s < 11'sd1) k = (prod == '0) ? SCL_ZERO : SCL_SAT;
    else k = SCL_SHIFT;
    return k;
  endfunction

  function automatic word_t scl_out(input scl_e k, input logic neg, input logic [92:0] qs);
    logic [92:0] mg;
    word_t       r;
    mg = (qs >> 1) + 93'(qs[0]);
    case (k)
      SCL_ZERO: r = '0;
      SCL_SAT:  r = neg ? WORD_MIN : WORD_MAX;
      default:  r = sat_mag(neg, (mg[92:64] != '0) ? '1 : mg[63:0]);
    endcase
    return r;
  endfunction

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_step_q <= '0;
      contact_q   <= '0;
      bmf_q       <= '0;
      dipole_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HALF_STEP:    half_step_q <= cfg_data_i[30:0];
        REG_CONTACT_GAIN: contact_q   <= word_t'(cfg_data_i);
        REG_BMF_GAIN:     bmf_q       <= word_t'(cfg_data_i);
        REG_DIPOLE_GAIN:  dipole_q    <= word_t'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q     <= '0;
      sq_vld_q <= '0;
      vg_q     <= '0;
      vp_q     <= '0;
    end else if (en) begin
      vf_q     <= {vf_q[3:0], in_valid_i};
      sq_vld_q <= {sq_vld_q[5:0], vf_q[4]};
      vg_q     <= {vg_q[7:0], sq_vld_q[6]};
      vp_q     <= {vp_q[2:0], tay_vld[24]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in0_q   <= in_data_i;
      side1_q <= '{re: in0_q.psi_re, im: in0_q.psi_im, interior: in0_q.interior, m: '0};
      sqre1_q <= mulq(in0_q.psi_re, in0_q.psi_re);
      sqim1_q <= mulq(in0_q.psi_im, in0_q.psi_im);
      dip1_q  <= mulq(dipole_q, in0_q.dipolar_field);
      ext1_q  <= in0_q.ext_potential;
      side2_q <= side1_q;
      d2_q    <= sat_add(sqre1_q, sqim1_q);
      v2_q    <= sat_add(ext1_q, dip1_q);
      side3_q <= side2_q;
      d3_q    <= d2_q;
      v3_q    <= v2_q;
      cd3_q   <= mulq(contact_q, d2_q);
      side4_q <= side3_q;
      d4_q    <= d3_q;
      v4_q    <= sat_add(v3_q, cd3_q);
    end
  end

  assign sq_in[0] = '{rem: '0, root: '0, rad: {1'b0, d4_q[30:0], 24'd0},
                      d: d4_q, v: v4_q, side: side4_q};

  for (genvar i = 0; i < 7; i++) begin : g_sqrt
    if (i > 0) begin : g_link
      assign sq_in[i] = sq_q[i-1];
    end
    always_comb begin
      logic [31:0] remx;
      logic [31:0] trial;
      sq_t         cur;
      cur = sq_in[i];
      for (int j = 0; j < 4; j++) begin
        remx    = {cur.rem[29:0], cur.rad[55:54]};
        trial   = {2'b00, cur.root, 2'b01};
        cur.rad = {cur.rad[53:0], 2'b00};
        if (remx >= trial) begin
          cur.rem  = remx - trial;
          cur.root = {cur.root[26:0], 1'b1};
        end else begin
          cur.rem  = remx;
          cur.root = {cur.root[26:0], 1'b0};
        end
      end
      sq_nx[i] = cur;
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i] <= sq_nx[i];
      end
    end
  end

  always_comb begin
    ax    = x_d_q[31] ? 32'(-x_d_q) : 32'(x_d_q);
    ny    = y_f_q[92:84];
    frac  = y_f_q[83:0];
    nfrac = (85'd1 << 84) - 85'(frac);
    nys   = signed'({1'b0, ny});
    if (!xneg_f_q) begin
      u_d = frac[83:24];
      m_d = nys;
    end else if (frac == '0) begin
      u_d = '0;
      m_d = -nys;
    end else begin
      u_d = nfrac[83:24];
      m_d = -nys - 10'sd1;
    end
    rfull = (124'(hh_q) << 62) + (124'(hl_q) << 30) + (124'(lh_q) << 32) + 124'(ll_q);
    tay0_d = '{term: ONE_Q60, sum: SUM_INIT, r: rfull[123:64], side: side_h_q};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q <= sq_q[6].side;
      v_a_q    <= sq_q[6].v;
      p_a_q    <= mulq(sq_q[6].d, signed'({4'b0, sq_q[6].root}));
      side_b_q <= side_a_q;
      v_b_q    <= v_a_q;
      b_b_q    <= mulq(bmf_q, p_a_q);
      side_c_q <= side_b_q;
      v_c_q    <= sat_add(v_b_q, b_b_q);
      side_d_q <= side_c_q;
      x_d_q    <= mulq(signed'({1'b0, half_step_q}), v_c_q);
      side_e_q <= side_d_q;
      xneg_e_q <= x_d_q[31];
      yh_e_q   <= 61'(ax) * 61'(LOG2E_Q60[60:32]);
      yl_e_q   <= 64'(ax) * 64'(LOG2E_Q60[31:0]);
      side_f_q <= side_e_q;
      xneg_f_q <= xneg_e_q;
      y_f_q    <= (93'(yh_e_q) << 32) + 93'(yl_e_q);
      side_g_q <= '{re: side_f_q.re, im: side_f_q.im, interior: side_f_q.interior, m: m_d};
      u_g_q    <= u_d;
      side_h_q <= side_g_q;
      hh_q     <= 62'(u_g_q[59:30]) * 62'(LN2_Q64[63:32]);
      hl_q     <= 62'(u_g_q[59:30]) * 62'(LN2_Q64[31:0]);
      lh_q     <= 62'(u_g_q[29:0]) * 62'(LN2_Q64[63:32]);
      ll_q     <= 62'(u_g_q[29:0]) * 62'(LN2_Q64[31:0]);
      tay0_q   <= tay0_d;
    end
  end

  assign tay_vld[0]  = vg_q[8];
  assign tay_data[0] = tay0_q;

  for (genvar i = 0; i < 24; i++) begin : g_series
    localparam logic [63:0] RECIP = 64'hFFFF_FFFF_FFFF_FFFF / (i + 1);
    itsp_taylor_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (tay_vld[i]),
      .data_i  (tay_data[i]),
      .k_i     (5'(i + 1)),
      .recip_i (RECIP),
      .valid_o (tay_vld[i+1]),
      .data_o  (tay_data[i+1])
    );
  end

  always_comb begin
    e_val = tay_data[24].sum[63] ? '0 : tay_data[24].sum[60:0];
    mre   = tay_data[24].side.re[31] ? 32'(-tay_data[24].side.re) : 32'(tay_data[24].side.re);
    mim   = tay_data[24].side.im[31] ? 32'(-tay_data[24].side.im) : 32'(tay_data[24].side.im);
    sh    = 7'(s_p2_q - 11'sd1);
    if (side_p3_q.interior) begin
      res_d.new_re = scl_out(kind_re_q, side_p3_q.re[31], qs_re_q);
      res_d.new_im = scl_out(kind_im_q, side_p3_q.im[31], qs_im_q);
    end else begin
      res_d.new_re = side_p3_q.re;
      res_d.new_im = side_p3_q.im;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_p1_q <= tay_data[24].side;
      prh_re_q  <= 61'(mre) * 61'(e_val[60:32]);
      prl_re_q  <= 64'(mre) * 64'(e_val[31:0]);
      prh_im_q  <= 61'(mim) * 61'(e_val[60:32]);
      prl_im_q  <= 64'(mim) * 64'(e_val[31:0]);
      side_p2_q <= side_p1_q;
      prod_re_q <= (93'(prh_re_q) << 32) + 93'(prl_re_q);
      prod_im_q <= (93'(prh_im_q) << 32) + 93'(prl_im_q);
      s_p2_q    <= {side_p1_q.m[9], side_p1_q.m} + 11'sd60;
      side_p3_q <= side_p2_q;
      kind_re_q <= scl_kind(prod_re_q, s_p2_q);
      kind_im_q <= scl_kind(prod_im_q, s_p2_q);
      qs_re_q   <= prod_re_q >> sh;
      qs_im_q   <= prod_im_q >> sh;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_vld_q && !out_stall_i) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else if (!vp_q[3]) begin
        out_vld_q <= 1'b0;
      end
    end else if (!out_vld_q) begin
      out_vld_q <= vp_q[3] && en;
    end else if (vp_q[3] && en) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld_q && !out_stall_i) begin
      out_q <= skid_vld_q ? skid_q : res_q;
    end else if (!out_vld_q) begin
      out_q <= res_q;
    end else if (en) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/itsp_taylor_step.sv
module itsp_taylor_step import itsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  tay_t        data_i,
  input  logic [4:0]  k_i,
  input  logic [63:0] recip_i,
  output logic        valid_o,
  output tay_t        data_o
);

  logic [4:0]  vld_q;
  logic [60:0] pa_q, pb_q;
  logic [59:0] pc_q, pd_q;
  tay_t        c1_q, c2_q, c3_q, c4_q;
  logic [59:0] a2_q, a3_q, a4_q;
  logic [59:0] qa_q, qb_q;
  logic [63:0] qc_q, qd_q;
  logic [59:0] q0_q;
  logic [120:0] full1;
  logic [123:0] full2;
  logic [65:0]  rem;
  logic [59:0]  q;
  tay_t         out_d;
  tay_t         out_q;

  always_comb begin
    full1 = (121'(pa_q) << 60) + ((121'(pb_q) + 121'(pc_q)) << 30) + 121'(pd_q);
    full2 = (124'(qa_q) << 64) + ((124'(qb_q) + 124'(qc_q)) << 32) + 124'(qd_q);
    rem   = 66'(a4_q) - 66'(q0_q) * 66'(k_i);
    q     = q0_q + 60'(rem >= 66'(k_i));
    out_d = c4_q;
    out_d.term = {1'b0, q};
    if (k_i[0]) out_d.sum = c4_q.sum - signed'({4'b0, q});
    else out_d.sum = c4_q.sum + signed'({4'b0, q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= 61'(data_i.term[60:30]) * 61'(data_i.r[59:30]);
      pb_q <= 61'(data_i.term[60:30]) * 61'(data_i.r[29:0]);
      pc_q <= 60'(data_i.term[29:0]) * 60'(data_i.r[59:30]);
      pd_q <= 60'(data_i.term[29:0]) * 60'(data_i.r[29:0]);
      c1_q <= data_i;
      a2_q <= full1[119:60];
      c2_q <= c1_q;
      qa_q <= 60'(a2_q[59:32]) * 60'(recip_i[63:32]);
      qb_q <= 60'(a2_q[59:32]) * 60'(recip_i[31:0]);
      qc_q <= 64'(a2_q[31:0]) * 64'(recip_i[63:32]);
      qd_q <= 64'(a2_q[31:0]) * 64'(recip_i[31:0]);
      a3_q <= a2_q;
      c3_q <= c2_q;
      q0_q <= full2[123:64];
      a4_q <= a3_q;
      c4_q <= c3_q;
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = out_q;

endmodule
